FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the word list decoder.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCWL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define FCWL_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define FCWL_ASSERT(lbl, clk, rst_n, prop)
`define FCWL_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: design/fcwl_pkg.sv
// Types and constants of the front coded word list decoder.
// No dependencies.
package fcwl_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDXO_W    = 6;
    localparam int unsigned ID_W      = 12;
    localparam int unsigned HDR_W     = 9;
    localparam int unsigned RES_CNT_W = 7;
    localparam int unsigned MAX_RESULTS = 64;

    localparam logic [HDR_W-1:0] HDR_LEN_F0 = 9'd52;
    localparam logic [HDR_W-1:0] HDR_LEN_F1 = 9'h1FE;
    localparam logic [BYTE_W-1:0] CHAR_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_FORMAT = 1'b0;   // paddr[2] of format_select

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_PREFIX = 6'b000010,
        PH_CHARS  = 6'b000100,
        PH_ID0    = 6'b001000,
        PH_ID1    = 6'b010000,
        PH_ID2    = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_READ = 3'b010,
        EM_LOAD = 3'b100
    } t_emit_state;

endpackage

FILE: design/fcwl_in_if.sv
// Byte input channel of the word list decoder.
// Depends on fcwl_pkg.
interface fcwl_in_if;
    import fcwl_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              resource_start;
    logic              resource_end;

    modport source (output valid, data_byte, resource_start, resource_end, input ready);
    modport sink   (input valid, data_byte, resource_start, resource_end, output ready);
endinterface

FILE: design/fcwl_out_if.sv
// Character output channel of the word list decoder.
// Depends on fcwl_pkg.
interface fcwl_out_if;
    import fcwl_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_code;
    logic [IDXO_W-1:0] char_index;
    logic [ID_W-1:0]   word_type;
    logic [ID_W-1:0]   word_group;
    logic              word_truncated;
    logic              end_of_word;

    modport source (output valid, char_code, char_index, word_type, word_group,
                    word_truncated, end_of_word, input ready);
    modport sink   (input valid, char_code, char_index, word_type, word_group,
                    word_truncated, end_of_word, output ready);
endinterface

FILE: design/fcwl_word_buf.sv
// Word buffer: one-port-write, one-port-read synchronous memory with valid bits.
// Entries never written read as zero. Depends on fcwl_pkg.
module fcwl_word_buf #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [fcwl_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [fcwl_pkg::BYTE_W-1:0] o_rd_data
);
    import fcwl_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [BYTE_W-1:0] r_mem_q;
    logic              r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_q <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_vld_q ? r_mem_q : '0;

endmodule

FILE: design/front_coded_word_list_decoder.sv
// Top level of the front coded word list decoder: parser, emitter, APB register.
// Depends on fcwl_pkg, fcwl_in_if, fcwl_out_if, fcwl_word_buf, assert_macros.svh.
//
//   channel  dir  handshake        beat
//   i_in     in   valid/ready      one resource byte with start/end marks
//   o_out    out  valid/ready      one word character with type/group
//   apb      in   psel/penable     format_select write/read, pready tied high
//
// A byte is taken whenever the emitter is idle. The third ID byte starts
// a burst of characters (buffer read, then output register load); no byte
// is taken until the last character of the burst is in the output register.
// Reset is synchronous; buffer entries read as zero until written (valid
// bits, no clearing pass). A stalled output only stalls the burst.
module front_coded_word_list_decoder #(
    parameter int unsigned MAX_WORD_LEN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcwl_pkg::PADDR_W-1:0] paddr,
    input  logic [fcwl_pkg::PDATA_W-1:0] pwdata,
    output logic [fcwl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    fcwl_in_if.sink                     i_in,
    fcwl_out_if.source                  o_out
);
    import fcwl_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int unsigned IDX_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int unsigned CMP_W  = IDX_W + BYTE_W;
    localparam int unsigned LEN_W  = (IDX_W > RES_CNT_W) ? IDX_W : RES_CNT_W;

    // configuration
    logic r_fmt;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FORMAT) ? PDATA_W'(r_fmt) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_FORMAT)) begin
            r_fmt <= pwdata[0];
        end
    end

    // parser state
    t_phase            r_phase, n_phase;
    logic [HDR_W-1:0]  r_hc, n_hc;
    logic [IDX_W-1:0]  r_wi, n_wi;
    logic [IDX_W-1:0]  r_wl, n_wl;
    logic              r_of, n_of;
    logic [BYTE_W-1:0] r_id_lo, n_id_lo;
    logic [BYTE_W-1:0] r_id_mid, n_id_mid;

    // emitter state
    t_emit_state          r_em;
    logic [RES_CNT_W-1:0] r_k;
    logic [RES_CNT_W-1:0] r_n;
    logic [ID_W-1:0]      r_type;
    logic [ID_W-1:0]      r_group;
    logic                 r_trunc;

    logic              acc;
    logic [BYTE_W-1:0] b;
    logic [HDR_W-1:0]  hdr_len;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_data;
    logic              launch;
    logic [LEN_W-1:0]  wl_ext;
    logic [RES_CNT_W-1:0] n_len;
    logic              n_trunc;
    logic [BYTE_W-1:0] rd_data;
    logic              out_load;
    logic              k_last;

    assign acc     = i_in.valid && i_in.ready;
    assign b       = i_in.data_byte;
    assign hdr_len = r_fmt ? HDR_LEN_F1 : HDR_LEN_F0;
    assign i_in.ready = (r_em == EM_IDLE);

    always_comb begin
        t_phase           ph;
        logic [IDX_W-1:0] wi;
        logic             put;
        n_phase  = r_phase;
        n_hc     = r_hc;
        n_wi     = r_wi;
        n_wl     = r_wl;
        n_of     = r_of;
        n_id_lo  = r_id_lo;
        n_id_mid = r_id_mid;
        wr_en    = 1'b0;
        wr_idx   = r_wi;
        wr_data  = b;
        launch   = 1'b0;
        put      = 1'b0;
        ph       = r_phase;
        if (i_in.resource_start) begin
            ph   = PH_HEADER;
            n_hc = '0;
            n_wi = '0;
            n_wl = '0;
            n_of = 1'b0;
        end
        wi = n_wi;
        case (ph)
            PH_HEADER: begin
                if ({1'b0, n_hc} + 10'd1 >= {1'b0, hdr_len}) begin
                    n_hc    = '0;
                    n_phase = PH_PREFIX;
                end else begin
                    n_hc    = n_hc + 1'b1;
                    n_phase = PH_HEADER;
                end
            end
            PH_PREFIX: begin
                if (CMP_W'(b) > CMP_W'(MAX_WORD_LEN)) begin
                    n_wi = IDX_W'(MAX_WORD_LEN);
                    n_of = 1'b1;
                end else begin
                    n_wi = IDX_W'(b);
                    n_of = 1'b0;
                end
                n_phase = PH_CHARS;
            end
            PH_CHARS: begin
                if (!r_fmt) begin
                    put     = 1'b1;
                    wr_data = b & CHAR_MASK;
                end else if (b != NUL_CHAR) begin
                    put = 1'b1;
                end
                if (put) begin
                    if (wi < IDX_W'(MAX_WORD_LEN)) begin
                        wr_en  = acc;
                        wr_idx = wi;
                        wi     = wi + 1'b1;
                    end else begin
                        n_of = 1'b1;
                    end
                end
                n_wi = wi;
                if ((!r_fmt && b[BYTE_W-1]) || (r_fmt && b == NUL_CHAR)) begin
                    n_wl    = wi;
                    n_phase = PH_ID0;
                end else begin
                    n_phase = PH_CHARS;
                end
            end
            PH_ID0: begin
                n_id_lo = b;
                n_phase = PH_ID1;
            end
            PH_ID1: begin
                n_id_mid = b;
                n_phase  = PH_ID2;
            end
            PH_ID2: begin
                launch  = 1'b1;
                n_phase = PH_PREFIX;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
        if (i_in.resource_end) begin
            n_phase = PH_HEADER;
            n_hc    = '0;
            n_wi    = '0;
        end
    end

    assign wl_ext  = LEN_W'(r_wl);
    assign n_trunc = r_of || (wl_ext > LEN_W'(MAX_RESULTS));
    assign n_len   = (wl_ext > LEN_W'(MAX_RESULTS)) ? RES_CNT_W'(MAX_RESULTS)
                                                    : RES_CNT_W'(wl_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hc     <= '0;
            r_wi     <= '0;
            r_wl     <= '0;
            r_of     <= 1'b0;
            r_id_lo  <= '0;
            r_id_mid <= '0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_hc     <= n_hc;
            r_wi     <= n_wi;
            r_wl     <= n_wl;
            r_of     <= n_of;
            r_id_lo  <= n_id_lo;
            r_id_mid <= n_id_mid;
        end
    end

    fcwl_word_buf #(
        .DEPTH  (MAX_WORD_LEN),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(wr_idx)),
        .i_wr_data (wr_data),
        .i_rd_en   (r_em == EM_READ),
        .i_rd_addr (ADDR_W'(r_k)),
        .o_rd_data (rd_data)
    );

    // emitter
    assign out_load = (r_em == EM_LOAD) && (!o_out.valid || o_out.ready);
    assign k_last   = (r_k + 1'b1) == r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em <= EM_IDLE;
            r_k  <= '0;
        end else begin
            case (r_em)
                EM_IDLE: begin
                    if (acc && launch && n_len != '0) begin
                        r_em <= EM_READ;
                        r_k  <= '0;
                    end
                end
                EM_READ: begin
                    r_em <= EM_LOAD;
                end
                EM_LOAD: begin
                    if (out_load) begin
                        r_k  <= r_k + 1'b1;
                        r_em <= k_last ? EM_IDLE : EM_READ;
                    end
                end
                default: begin
                    r_em <= EM_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && launch) begin
            r_n     <= n_len;
            r_trunc <= n_trunc;
            r_type  <= {r_id_mid[7:4], r_id_lo};
            r_group <= {r_id_mid[3:0], b};
        end
    end

    logic r_out_valid;
    logic [BYTE_W-1:0] r_out_char;
    logic [IDXO_W-1:0] r_out_idx;
    logic [ID_W-1:0]   r_out_type;
    logic [ID_W-1:0]   r_out_group;
    logic              r_out_trunc;
    logic              r_out_eow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char  <= rd_data;
            r_out_idx   <= r_k[IDXO_W-1:0];
            r_out_type  <= r_type;
            r_out_group <= r_group;
            r_out_trunc <= r_trunc;
            r_out_eow   <= k_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.char_code      = r_out_char;
    assign o_out.char_index     = r_out_idx;
    assign o_out.word_type      = r_out_type;
    assign o_out.word_group     = r_out_group;
    assign o_out.word_truncated = r_out_trunc;
    assign o_out.end_of_word    = r_out_eow;

    `FCWL_ASSERT(a_k_in_range, i_clk, i_rst_n, (r_em != EM_IDLE) |-> (r_k < r_n))
    `FCWL_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> o_out.valid)
    `FCWL_NEVER(a_wi_bound, i_clk, i_rst_n, r_wi > IDX_W'(MAX_WORD_LEN))
    `FCWL_ASSERT(a_end_hdr, i_clk, i_rst_n, (acc && i_in.resource_end) |=> (r_phase == PH_HEADER))

endmodule
